[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the line framer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion on an explicit clock and active-low reset.
`define LFJC_ASSERT_CR(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assertion on the default clock and reset of the block.
`define LFJC_ASSERT(lbl, prop, msg) \
  `LFJC_ASSERT_CR(lbl, clk_i, rst_ni, prop, msg)

`endif

[src/lfjc_pkg.sv]
// ----------------------------------------------------------------------------
// lfjc_pkg
// Shared constants and types for the line framer with JSON object check.
// ----------------------------------------------------------------------------
`default_nettype none

package lfjc_pkg;

  localparam int LINE_BYTES = 512;
  localparam int CNT_W      = $clog2(LINE_BYTES);
  localparam int LEN_W      = 9;
  localparam int DEPTH_W    = 9;

  localparam logic [CNT_W-1:0]   CNT_LAST  = CNT_W'(LINE_BYTES - 1);
  localparam logic [LEN_W-1:0]   LEN_FULL  = LEN_W'(LINE_BYTES - 1);
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};

  localparam logic [7:0] CH_LF     = 8'd10;
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_NUL    = 8'd0;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_QUOTE  = 8'd34;
  localparam logic [7:0] CH_BSLASH = 8'd92;
  localparam logic [7:0] CH_LBRACE = 8'd123;
  localparam logic [7:0] CH_RBRACE = 8'd125;
  localparam logic [7:0] CH_LBRACK = 8'd91;
  localparam logic [7:0] CH_RBRACK = 8'd93;

  typedef enum logic [1:0] {
    VERDICT_VALID    = 2'd0,
    VERDICT_NOT_JSON = 2'd1,
    VERDICT_OVERFLOW = 2'd2,
    VERDICT_EMPTY    = 2'd3
  } verdict_e;

  typedef struct packed {
    logic             hit;
    verdict_e         verdict;
    logic [LEN_W-1:0] len;
  } result_t;

endpackage

`default_nettype wire

[src/lfjc_checker.sv]
// ----------------------------------------------------------------------------
// lfjc_checker
// Per-line scan state and the verdict logic, updated once per processed byte.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lfjc_checker (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire logic [7:0]       byte_i,
  output lfjc_pkg::result_t     result_o
);

  logic [lfjc_pkg::CNT_W-1:0]   count_q, count_d;
  logic                         in_str_q, in_str_d;
  logic                         esc_q, esc_d;
  logic [lfjc_pkg::DEPTH_W-1:0] brace_q, brace_d;
  logic [lfjc_pkg::DEPTH_W-1:0] brack_q, brack_d;
  logic [1:0]                   content_q, content_d;
  logic                         opened_q, opened_d;
  logic                         last_close_q, last_close_d;
  logic                         top_closed_q, top_closed_d;
  logic                         serr_q, serr_d;
  logic                         ovf_q, ovf_d;
  logic                         zero_seen_q, zero_seen_d;
  logic                         zero_first_q, zero_first_d;

  logic                         is_eol;
  logic                         is_blank;
  logic [lfjc_pkg::CNT_W+lfjc_pkg::LEN_W-1:0] len_ext;
  lfjc_pkg::verdict_e           verdict;

  assign is_eol   = (byte_i == lfjc_pkg::CH_LF) || (byte_i == lfjc_pkg::CH_CR);
  assign is_blank = (byte_i == lfjc_pkg::CH_SPACE) || (byte_i == lfjc_pkg::CH_TAB);
  assign len_ext  = {{lfjc_pkg::LEN_W{1'b0}}, count_q};

  always_comb begin
    if (ovf_q) begin
      verdict = lfjc_pkg::VERDICT_OVERFLOW;
    end else if (zero_seen_q && zero_first_q) begin
      verdict = lfjc_pkg::VERDICT_EMPTY;
    end else if ((content_q == 2'd2) && opened_q && last_close_q && !serr_q &&
                 !in_str_q && !esc_q && (brace_q == '0) && (brack_q == '0)) begin
      verdict = lfjc_pkg::VERDICT_VALID;
    end else begin
      verdict = lfjc_pkg::VERDICT_NOT_JSON;
    end
    result_o.hit     = is_eol && (count_q != '0);
    result_o.verdict = verdict;
    result_o.len     = len_ext[lfjc_pkg::LEN_W-1:0];
  end

  always_comb begin
    count_d      = count_q;
    in_str_d     = in_str_q;
    esc_d        = esc_q;
    brace_d      = brace_q;
    brack_d      = brack_q;
    content_d    = content_q;
    opened_d     = opened_q;
    last_close_d = last_close_q;
    top_closed_d = top_closed_q;
    serr_d       = serr_q;
    ovf_d        = ovf_q;
    zero_seen_d  = zero_seen_q;
    zero_first_d = zero_first_q;

    if (is_eol) begin
      count_d      = '0;
      in_str_d     = 1'b0;
      esc_d        = 1'b0;
      brace_d      = '0;
      brack_d      = '0;
      content_d    = 2'd0;
      opened_d     = 1'b0;
      last_close_d = 1'b0;
      top_closed_d = 1'b0;
      serr_d       = 1'b0;
      ovf_d        = 1'b0;
      zero_seen_d  = 1'b0;
      zero_first_d = 1'b0;
    end else if (count_q < lfjc_pkg::CNT_LAST) begin
      count_d = count_q + 1'b1;
      if (!zero_seen_q) begin
        if (byte_i == lfjc_pkg::CH_NUL) begin
          zero_seen_d  = 1'b1;
          zero_first_d = (count_q == '0);
        end else begin
          if (!is_blank) begin
            if (content_q == 2'd0) begin
              opened_d = (byte_i == lfjc_pkg::CH_LBRACE);
            end
            if (top_closed_q) begin
              serr_d = 1'b1;
            end
            last_close_d = (byte_i == lfjc_pkg::CH_RBRACE);
            if (content_q != 2'd2) begin
              content_d = content_q + 2'd1;
            end
          end
          if (!serr_d) begin
            if (in_str_q) begin
              if (esc_q) begin
                esc_d = 1'b0;
              end else if (byte_i == lfjc_pkg::CH_BSLASH) begin
                esc_d = 1'b1;
              end else if (byte_i == lfjc_pkg::CH_QUOTE) begin
                in_str_d = 1'b0;
              end
            end else begin
              case (byte_i)
                lfjc_pkg::CH_QUOTE: begin
                  in_str_d = 1'b1;
                end
                lfjc_pkg::CH_LBRACE: begin
                  if (brace_q != lfjc_pkg::DEPTH_MAX) begin
                    brace_d = brace_q + 1'b1;
                  end
                end
                lfjc_pkg::CH_RBRACE: begin
                  if (brace_q == '0) begin
                    serr_d = 1'b1;
                  end else begin
                    brace_d = brace_q - 1'b1;
                    if (brace_q == lfjc_pkg::DEPTH_W'(1)) begin
                      top_closed_d = 1'b1;
                    end
                  end
                end
                lfjc_pkg::CH_LBRACK: begin
                  if (brack_q != lfjc_pkg::DEPTH_MAX) begin
                    brack_d = brack_q + 1'b1;
                  end
                end
                lfjc_pkg::CH_RBRACK: begin
                  if (brack_q == '0) begin
                    serr_d = 1'b1;
                  end else begin
                    brack_d = brack_q - 1'b1;
                  end
                end
                default: begin
                end
              endcase
            end
          end
        end
      end
    end else begin
      ovf_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      in_str_q     <= 1'b0;
      esc_q        <= 1'b0;
      brace_q      <= '0;
      brack_q      <= '0;
      content_q    <= 2'd0;
      opened_q     <= 1'b0;
      last_close_q <= 1'b0;
      top_closed_q <= 1'b0;
      serr_q       <= 1'b0;
      ovf_q        <= 1'b0;
      zero_seen_q  <= 1'b0;
      zero_first_q <= 1'b0;
    end else if (step_i) begin
      count_q      <= count_d;
      in_str_q     <= in_str_d;
      esc_q        <= esc_d;
      brace_q      <= brace_d;
      brack_q      <= brack_d;
      content_q    <= content_d;
      opened_q     <= opened_d;
      last_close_q <= last_close_d;
      top_closed_q <= top_closed_d;
      serr_q       <= serr_d;
      ovf_q        <= ovf_d;
      zero_seen_q  <= zero_seen_d;
      zero_first_q <= zero_first_d;
    end
  end

  `LFJC_ASSERT(a_eol_clears, step_i && is_eol |=> (count_q == '0) && !ovf_q && !zero_seen_q, "line end did not clear the scan state")
  `LFJC_ASSERT(a_ovf_at_full, ovf_q |-> count_q == lfjc_pkg::CNT_LAST, "overflow flagged below full count")
  `LFJC_ASSERT(a_esc_in_string, esc_q |-> in_str_q, "escape flag set outside a string")

endmodule

`default_nettype wire

[src/lfjc_out_reg.sv]
// ----------------------------------------------------------------------------
// lfjc_out_reg
// Result register that holds one verdict until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module lfjc_out_reg (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       load_i,
  input  wire lfjc_pkg::result_t          result_i,
  input  wire logic                       ready_i,
  output logic                            space_o,
  output logic                            valid_o,
  output logic [1:0]                      verdict_o,
  output logic [lfjc_pkg::LEN_W-1:0]      len_o
);

  logic               valid_q, valid_d;
  lfjc_pkg::result_t  res_q;

  assign space_o = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  assign valid_o   = valid_q;
  assign verdict_o = res_q.verdict;
  assign len_o     = res_q.len;

endmodule

`default_nettype wire

[src/line_framer_json_object_check_unit.sv]
// A byte that ends a line is registered in the input stage, then its result in the result register.
// One byte per cycle while the single result register has space; it is the only stall point.
// A line end stalls input only while an earlier result waits and is not taken.
// Reset is asynchronous and active low; it clears the scan state and both valid flags.
// ----------------------------------------------------------------------------
// line_framer_json_object_check_unit
// Frames received bytes into lines and gives a JSON object verdict per line.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module line_framer_json_object_check_unit (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [7:0]                 rx_data_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [1:0]                      verdict_o,
  output logic [lfjc_pkg::LEN_W-1:0]      line_length_o
);

  logic               s1_valid_q, s1_valid_d;
  logic [7:0]         s1_byte_q;
  logic               s1_fire;
  logic               out_space;
  logic               in_fire;
  lfjc_pkg::result_t  result;

  assign s1_fire    = s1_valid_q && (!result.hit || out_space);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;
  assign s1_valid_d = in_fire || (s1_valid_q && !s1_fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q <= rx_data_i;
    end
  end

  lfjc_checker u_checker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (s1_fire),
    .byte_i   (s1_byte_q),
    .result_o (result)
  );

  lfjc_out_reg u_out_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (s1_fire && result.hit),
    .result_i  (result),
    .ready_i   (out_ready_i),
    .space_o   (out_space),
    .valid_o   (out_valid_o),
    .verdict_o (verdict_o),
    .len_o     (line_length_o)
  );

  `LFJC_ASSERT(a_stall_cause, !in_ready_o |-> s1_valid_q && out_valid_o && !out_ready_i, "input stalled without a blocked result")
  `LFJC_ASSERT(a_ovf_len, out_valid_o && (verdict_o == lfjc_pkg::VERDICT_OVERFLOW) |-> line_length_o == lfjc_pkg::LEN_FULL, "overflow verdict with short length")
  `LFJC_ASSERT(a_result_loaded, s1_fire && result.hit |=> out_valid_o, "line result not registered")

endmodule

`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Line framer JSON check testbench
// Sends byte streams framed into lines, from directed rows and from random
// objects, noise and long lines, under random sender gaps and receiver stalls.
// Each line verdict and length is checked against a scan model kept here.
// ----------------------------------------------------------------------------

module testbench;

  typedef struct packed {
    logic [7:0]        data;
    logic              typed;
    lfjc_pkg::result_t want;
  } stim_row_t;

  localparam lfjc_pkg::result_t NO_RES = '{1'b0, lfjc_pkg::VERDICT_VALID, 9'd0};

  localparam stim_row_t DIRECTED [25] = '{
    '{lfjc_pkg::CH_LF,     1'b1, NO_RES},
    '{lfjc_pkg::CH_LBRACE, 1'b0, NO_RES},
    '{lfjc_pkg::CH_RBRACE, 1'b0, NO_RES},
    '{lfjc_pkg::CH_CR,     1'b1, '{1'b1, lfjc_pkg::VERDICT_VALID, 9'd2}},
    '{lfjc_pkg::CH_NUL,    1'b0, NO_RES},
    '{lfjc_pkg::CH_LF,     1'b1, '{1'b1, lfjc_pkg::VERDICT_EMPTY, 9'd1}},
    '{lfjc_pkg::CH_TAB,    1'b0, NO_RES},
    '{lfjc_pkg::CH_LBRACE, 1'b0, NO_RES},
    '{lfjc_pkg::CH_QUOTE,  1'b0, NO_RES},
    '{lfjc_pkg::CH_BSLASH, 1'b0, NO_RES},
    '{lfjc_pkg::CH_QUOTE,  1'b0, NO_RES},
    '{lfjc_pkg::CH_QUOTE,  1'b0, NO_RES},
    '{lfjc_pkg::CH_RBRACE, 1'b0, NO_RES},
    '{lfjc_pkg::CH_SPACE,  1'b0, NO_RES},
    '{lfjc_pkg::CH_CR,     1'b0, NO_RES},
    '{lfjc_pkg::CH_RBRACK, 1'b0, NO_RES},
    '{lfjc_pkg::CH_LF,     1'b1, '{1'b1, lfjc_pkg::VERDICT_NOT_JSON, 9'd1}},
    '{lfjc_pkg::CH_LBRACE, 1'b0, NO_RES},
    '{lfjc_pkg::CH_RBRACE, 1'b0, NO_RES},
    '{lfjc_pkg::CH_RBRACE, 1'b0, NO_RES},
    '{lfjc_pkg::CH_LF,     1'b0, NO_RES},
    '{lfjc_pkg::CH_LBRACK, 1'b0, NO_RES},
    '{lfjc_pkg::CH_NUL,    1'b0, NO_RES},
    '{8'hFF,               1'b0, NO_RES},
    '{lfjc_pkg::CH_LF,     1'b0, NO_RES}
  };

  logic                        clk_i;
  logic                        rst_ni      = 1'b0;
  logic                        in_valid_i  = 1'b0;
  logic                        in_ready_o;
  logic [7:0]                  rx_data_i   = 8'h00;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  logic [1:0]                  verdict_o;
  logic [lfjc_pkg::LEN_W-1:0]  line_length_o;

  line_framer_json_object_check_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .rx_data_i    (rx_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .verdict_o    (verdict_o),
    .line_length_o(line_length_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("simulation failed");
    $finish;
  end

  // Scan state of the line in progress.
  logic [lfjc_pkg::CNT_W-1:0]   stored_cnt  = '0;
  logic [lfjc_pkg::DEPTH_W-1:0] brace_lvl   = '0;
  logic [lfjc_pkg::DEPTH_W-1:0] bracket_lvl = '0;
  logic [1:0]                   nonblank_cnt = '0;
  logic str_open, escape_next, starts_brace, ends_brace, top_closed;
  logic struct_bad, too_long, nul_seen, nul_first;

  initial begin
    {str_open, escape_next, starts_brace, ends_brace, top_closed} = '0;
    {struct_bad, too_long, nul_seen, nul_first} = '0;
  end

  lfjc_pkg::result_t verdict_q [$];
  logic [7:0]        line_q [$];
  int                err_cnt    = 0;
  int                items_sent = 0;
  int                burst_left = 0;
  int                gap_left   = 0;
  int                rx_mode    = 0;
  int                rx_phase   = 0;
  int                rx_hold    = 0;

  function automatic void track_json_byte(input logic [7:0] b);
    logic blank;
    blank = (b == lfjc_pkg::CH_SPACE) || (b == lfjc_pkg::CH_TAB);
    if (!blank) begin
      if (nonblank_cnt == 2'd0) starts_brace = (b == lfjc_pkg::CH_LBRACE);
      if (top_closed) struct_bad = 1'b1;
      ends_brace = (b == lfjc_pkg::CH_RBRACE);
      if (nonblank_cnt < 2'd2) nonblank_cnt++;
    end
    if (struct_bad) return;
    if (str_open) begin
      if (escape_next) escape_next = 1'b0;
      else if (b == lfjc_pkg::CH_BSLASH) escape_next = 1'b1;
      else if (b == lfjc_pkg::CH_QUOTE) str_open = 1'b0;
      return;
    end
    case (b)
      lfjc_pkg::CH_QUOTE: str_open = 1'b1;
      lfjc_pkg::CH_LBRACE: if (brace_lvl != lfjc_pkg::DEPTH_MAX) brace_lvl++;
      lfjc_pkg::CH_RBRACE: begin
        if (brace_lvl == '0) begin
          struct_bad = 1'b1;
        end else begin
          brace_lvl--;
          if (brace_lvl == '0) top_closed = 1'b1;
        end
      end
      lfjc_pkg::CH_LBRACK: if (bracket_lvl != lfjc_pkg::DEPTH_MAX) bracket_lvl++;
      lfjc_pkg::CH_RBRACK: begin
        if (bracket_lvl == '0) struct_bad = 1'b1;
        else bracket_lvl--;
      end
      default: ;
    endcase
  endfunction

  // Advances the line scan by one accepted byte and returns the line verdict
  // when the byte ends a non-empty line.
  function automatic lfjc_pkg::result_t judge_byte(input logic [7:0] b);
    lfjc_pkg::result_t r;
    r = NO_RES;
    if (b == lfjc_pkg::CH_LF || b == lfjc_pkg::CH_CR) begin
      if (stored_cnt != '0) begin
        r.hit = 1'b1;
        r.len = stored_cnt;
        if (too_long) r.verdict = lfjc_pkg::VERDICT_OVERFLOW;
        else if (nul_seen && nul_first) r.verdict = lfjc_pkg::VERDICT_EMPTY;
        else if (nonblank_cnt == 2'd2 && starts_brace && ends_brace && !struct_bad &&
                 !str_open && !escape_next && brace_lvl == '0 && bracket_lvl == '0)
          r.verdict = lfjc_pkg::VERDICT_VALID;
        else r.verdict = lfjc_pkg::VERDICT_NOT_JSON;
      end
      stored_cnt   = '0;
      brace_lvl    = '0;
      bracket_lvl  = '0;
      nonblank_cnt = '0;
      {str_open, escape_next, starts_brace, ends_brace, top_closed} = '0;
      {struct_bad, too_long, nul_seen, nul_first} = '0;
    end else if (stored_cnt < lfjc_pkg::CNT_LAST) begin
      if (!nul_seen) begin
        if (b == lfjc_pkg::CH_NUL) begin
          nul_seen  = 1'b1;
          nul_first = (stored_cnt == '0);
        end else begin
          track_json_byte(b);
        end
      end
      stored_cnt++;
    end else begin
      too_long = 1'b1;
    end
    return r;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    while (gap_left > 0) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      gap_left--;
    end
    in_valid_i <= 1'b1;
    rx_data_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 48);
      gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    end
  endtask

  task automatic send_line();
    lfjc_pkg::result_t r;
    foreach (line_q[i]) begin
      send_byte(line_q[i]);
      r = judge_byte(line_q[i]);
      if (r.hit) verdict_q.push_back(r);
    end
  endtask

  // Printable or high byte that is neither a quote nor a backslash.
  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(32, 255));
    while (b == lfjc_pkg::CH_QUOTE || b == lfjc_pkg::CH_BSLASH);
    return b;
  endfunction

  function automatic void add_blanks(input int n);
    repeat (n) line_q.push_back($urandom_range(0, 1) ? lfjc_pkg::CH_SPACE : lfjc_pkg::CH_TAB);
  endfunction

  // Well-formed object with random nesting, strings, escapes and scalars.
  function automatic void build_object();
    logic [7:0] close_q [$];
    int n;
    add_blanks($urandom_range(0, 2));
    line_q.push_back(lfjc_pkg::CH_LBRACE);
    close_q.push_back(lfjc_pkg::CH_RBRACE);
    repeat ($urandom_range(0, 10)) begin
      case ($urandom_range(0, 5))
        0: if (close_q.size() < 8) begin
          line_q.push_back(lfjc_pkg::CH_LBRACE);
          close_q.push_back(lfjc_pkg::CH_RBRACE);
        end
        1: if (close_q.size() < 8) begin
          line_q.push_back(lfjc_pkg::CH_LBRACK);
          close_q.push_back(lfjc_pkg::CH_RBRACK);
        end
        2: if (close_q.size() > 1) line_q.push_back(close_q.pop_back());
        3: begin
          line_q.push_back(lfjc_pkg::CH_QUOTE);
          n = $urandom_range(0, 6);
          repeat (n) begin
            if ($urandom_range(0, 4) == 0) begin
              line_q.push_back(lfjc_pkg::CH_BSLASH);
              line_q.push_back(8'($urandom_range(32, 255)));
            end else begin
              line_q.push_back(text_byte());
            end
          end
          line_q.push_back(lfjc_pkg::CH_QUOTE);
        end
        4: line_q.push_back(8'($urandom_range(44, 58)));
        default: add_blanks(1);
      endcase
    end
    while (close_q.size() > 0) line_q.push_back(close_q.pop_back());
    add_blanks($urandom_range(0, 2));
  endfunction

  function automatic void damage_line();
    int pos;
    pos = $urandom_range(0, line_q.size() - 1);
    case ($urandom_range(0, 3))
      0: line_q.insert(pos, 8'($urandom_range(0, 255)));
      1: line_q.delete(pos);
      2: line_q.insert(pos, lfjc_pkg::CH_NUL);
      default: line_q.push_back($urandom_range(0, 1) ? lfjc_pkg::CH_LBRACE : text_byte());
    endcase
  endfunction

  function automatic void build_line();
    int k;
    int target;
    line_q.delete();
    k = $urandom_range(0, 199);
    if (k < 2) begin
      target = ($urandom_range(0, 3) == 0) ? $urandom_range(600, 700) : $urandom_range(509, 513);
      line_q.push_back(lfjc_pkg::CH_LBRACE);
      line_q.push_back(lfjc_pkg::CH_QUOTE);
      while (line_q.size() < target - 2) line_q.push_back(text_byte());
      line_q.push_back(lfjc_pkg::CH_QUOTE);
      line_q.push_back(lfjc_pkg::CH_RBRACE);
    end else if (k < 130) begin
      build_object();
      if ($urandom_range(0, 3) == 0) damage_line();
    end else if (k < 155) begin
      repeat ($urandom_range(1, 16)) line_q.push_back(8'($urandom_range(0, 255)));
    end else if (k < 170) begin
      line_q.push_back(lfjc_pkg::CH_NUL);
      repeat ($urandom_range(0, 4)) line_q.push_back(8'($urandom_range(0, 255)));
    end else if (k < 180) begin
      add_blanks($urandom_range(0, 3));
    end else begin
      build_object();
      damage_line();
      damage_line();
    end
    line_q.push_back($urandom_range(0, 1) ? lfjc_pkg::CH_CR : lfjc_pkg::CH_LF);
    if ($urandom_range(0, 3) == 0) line_q.push_back(lfjc_pkg::CH_LF);
  endfunction

  initial begin
    lfjc_pkg::result_t r;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[i]) begin
      send_byte(DIRECTED[i].data);
      r = judge_byte(DIRECTED[i].data);
      if (DIRECTED[i].typed) r = DIRECTED[i].want;
      if (r.hit) verdict_q.push_back(r);
    end

    while (items_sent < 1900) begin
      build_line();
      send_line();
    end
    in_valid_i <= 1'b0;

    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    lfjc_pkg::result_t want;
    if (out_valid_o && out_ready_i) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: result with no request pending, got verdict %0d length %0d",
                 $time, verdict_o, line_length_o);
        err_cnt++;
      end else begin
        want = verdict_q.pop_front();
        if (verdict_o !== want.verdict) begin
          $display("%0t: verdict expected %0d, actual %0d", $time, want.verdict, verdict_o);
          err_cnt++;
        end
        if (line_length_o !== want.len) begin
          $display("%0t: line_length expected %0d, actual %0d", $time, want.len,
                   line_length_o);
          err_cnt++;
        end
      end
    end

    // The receiver switches between always ready, random ready and long stalls.
    if (rx_phase == 0) begin
      rx_mode  = $urandom_range(0, 2);
      rx_phase = $urandom_range(100, 400);
    end else begin
      rx_phase--;
    end
    if (rx_hold > 0) begin
      rx_hold--;
    end else begin
      case (rx_mode)
        0: out_ready_i <= 1'b1;
        1: begin
          out_ready_i <= 1'($urandom_range(0, 1));
          rx_hold = $urandom_range(0, 2);
        end
        default: begin
          out_ready_i <= !out_ready_i;
          rx_hold = out_ready_i ? $urandom_range(4, 16) : 0;
        end
      endcase
    end
  end

endmodule
